// ===== hw/rtl/prefix_varint_codec_macros.svh =====
// ----------------------------------------------------------------------------
// Prefix varint codec assertion macros
// Shorthands for clocked implication checks under the async reset.
// ----------------------------------------------------------------------------
`ifndef PREFIX_VARINT_CODEC_MACROS_SVH
`define PREFIX_VARINT_CODEC_MACROS_SVH

// same-cycle implication
`define PVC_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PVC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/pvc_pkg.sv =====
// ----------------------------------------------------------------------------
// Prefix varint codec package
// Shared widths, codes and types of the codec.
// ----------------------------------------------------------------------------
`default_nettype none

package pvc_pkg;

	localparam int VAL_W     = 64;
	localparam int BYTE_W    = 8;
	localparam int LEN_W     = 4;
	localparam int S_TDATA_W = 72;
	localparam int M_TDATA_W = 80;

	localparam logic [LEN_W-1:0] LEN_MAX     = 4'd9;
	localparam logic [LEN_W-1:0] SEARCH_LAST = 4'd8;

	localparam logic ACT_ENCODE = 1'b0;
	localparam logic ACT_DECODE = 1'b1;

	localparam logic KIND_BYTE  = 1'b0;
	localparam logic KIND_VALUE = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SEARCH = 4'b0010,
		ST_EMIT   = 4'b0100,
		ST_DEC    = 4'b1000
	} state_t;

	typedef struct packed {
		logic [VAL_W-1:0] ext;
		logic             fits;
	} sext_res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pvc_sext_unit.sv =====
// ----------------------------------------------------------------------------
// Prefix varint codec sign-extend unit
// Sign-extends the low 7*k bits of a word and tells whether that is lossless.
// ----------------------------------------------------------------------------
`default_nettype none

module pvc_sext_unit (
	input  wire logic [pvc_pkg::VAL_W-1:0] val,
	input  wire logic [pvc_pkg::LEN_W-1:0] k,
	output pvc_pkg::sext_res_t             res
);
	import pvc_pkg::*;

	logic [VAL_W-1:0] ext;

	always_comb begin
		unique case (k)
			4'd1: ext = {{57{val[6]}},  val[6:0]};
			4'd2: ext = {{50{val[13]}}, val[13:0]};
			4'd3: ext = {{43{val[20]}}, val[20:0]};
			4'd4: ext = {{36{val[27]}}, val[27:0]};
			4'd5: ext = {{29{val[34]}}, val[34:0]};
			4'd6: ext = {{22{val[41]}}, val[41:0]};
			4'd7: ext = {{15{val[48]}}, val[48:0]};
			4'd8: ext = {{8{val[55]}},  val[55:0]};
			default: ext = val;
		endcase
	end

	assign res.ext  = ext;
	assign res.fits = (ext == val);

endmodule

`default_nettype wire

// ===== hw/rtl/pvc_byte_pick.sv =====
// ----------------------------------------------------------------------------
// Prefix varint codec byte picker
// Selects code byte k of a value of length L and adds the length prefix.
// ----------------------------------------------------------------------------
`default_nettype none

module pvc_byte_pick (
	input  wire logic [pvc_pkg::VAL_W-1:0]  val,
	input  wire logic [pvc_pkg::LEN_W-1:0]  len,
	input  wire logic [pvc_pkg::LEN_W-1:0]  idx,
	output logic      [pvc_pkg::BYTE_W-1:0] code_byte
);
	import pvc_pkg::*;

	logic [LEN_W-1:0]  pos;
	logic [BYTE_W-1:0] raw;
	logic [BYTE_W-1:0] prefix;
	logic [BYTE_W-1:0] keep;

	assign pos    = len - idx - 4'd1;
	assign raw    = val[{pos[2:0], 3'b000} +: BYTE_W];
	assign prefix = ~(8'hFF >> (len - 4'd1));
	assign keep   = 8'hFF >> len;

	always_comb begin
		if (idx == '0) begin
			code_byte = (raw & keep) | prefix;
		end else begin
			code_byte = raw;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/prefix_varint_codec.sv =====
// ----------------------------------------------------------------------------
// Prefix varint codec
// Signed 64-bit prefix-length varint encoder and byte-wise decoder.
// ----------------------------------------------------------------------------
// channel  dir  tdata                                  tuser     tlast
// s_*      in   value_in[63:0] byte_in[71:64]          action    -
// m_*      out  byte_out code_length value_out (80b)   kind      last_byte
//
// Encode: an accept step, a length search that steps the shared sign-extend unit
// for k = 1..8, then one byte per cycle while the output is not stalled (L bytes).
// Decode: each byte beat is accepted in IDLE, then updates through the same unit in DEC.
// Async reset clears the sequencer, output valid and the decode state.
// Output stalls hold the emit and decode-result steps; no input beat is taken until idle.
// ----------------------------------------------------------------------------
`default_nettype none

module prefix_varint_codec (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	input  wire logic [pvc_pkg::S_TDATA_W-1:0]      s_tdata,  // value_in, byte_in
	input  wire logic                               s_tuser,  // action
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	output logic      [pvc_pkg::M_TDATA_W-1:0]      m_tdata,  // byte_out, code_length, value_out
	output logic                                    m_tuser,  // kind
	output logic                                    m_tlast
);
	import pvc_pkg::*;

	state_t            state_q;
	logic [LEN_W-1:0]  cnt_q;
	logic [LEN_W-1:0]  len_q;
	logic [LEN_W-1:0]  bytes_seen_q;
	logic [LEN_W-1:0]  exp_len_q;
	logic [VAL_W-1:0]  acc_q;
	logic [VAL_W-1:0]  val_q;
	logic [BYTE_W-1:0] byte_q;
	logic              m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;
	logic              m_tuser_q;
	logic              m_tlast_q;

	logic              take;
	logic              out_free;
	logic              first;
	logic [LEN_W-1:0]  lead_len;
	logic [VAL_W-1:0]  acc_nxt;
	logic [LEN_W-1:0]  len_nxt;
	logic [LEN_W-1:0]  seen_nxt;
	logic              done;
	logic [VAL_W-1:0]  unit_val;
	logic [LEN_W-1:0]  unit_k;
	sext_res_t         sres;
	logic [BYTE_W-1:0] enc_byte;
	logic              enc_last;
	logic              emit_ld;
	logic              dec_ld;

	assign s_tready = (state_q == ST_IDLE);
	assign take     = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		priority casez (byte_q)
			8'b0???????: lead_len = 4'd1;
			8'b10??????: lead_len = 4'd2;
			8'b110?????: lead_len = 4'd3;
			8'b1110????: lead_len = 4'd4;
			8'b11110???: lead_len = 4'd5;
			8'b111110??: lead_len = 4'd6;
			8'b1111110?: lead_len = 4'd7;
			8'b11111110: lead_len = 4'd8;
			default:     lead_len = LEN_MAX;
		endcase
	end

	assign first    = (bytes_seen_q == '0);
	assign len_nxt  = first ? lead_len : exp_len_q;
	assign seen_nxt = first ? 4'd1 : bytes_seen_q + 4'd1;
	assign done     = (seen_nxt >= len_nxt);

	always_comb begin
		if (!first) begin
			acc_nxt = {acc_q[VAL_W-BYTE_W-1:0], byte_q};
		end else if (lead_len < SEARCH_LAST) begin
			acc_nxt = {{(VAL_W-BYTE_W){1'b0}}, byte_q & (8'hFF >> lead_len)};
		end else begin
			acc_nxt = '0;
		end
	end

	assign unit_val = (state_q == ST_SEARCH) ? val_q : acc_nxt;
	assign unit_k   = (state_q == ST_SEARCH) ? cnt_q : len_nxt;

	pvc_sext_unit u_sext (
		.val (unit_val),
		.k   (unit_k),
		.res (sres)
	);

	pvc_byte_pick u_pick (
		.val       (val_q),
		.len       (len_q),
		.idx       (cnt_q),
		.code_byte (enc_byte)
	);

	assign enc_last = (cnt_q == len_q - 4'd1);
	assign emit_ld  = (state_q == ST_EMIT) && out_free;
	assign dec_ld   = (state_q == ST_DEC) && done && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			len_q        <= '0;
			bytes_seen_q <= '0;
			exp_len_q    <= '0;
			acc_q        <= '0;
			m_tvalid_q   <= 1'b0;
		end else begin
			if (emit_ld || dec_ld) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						cnt_q   <= 4'd1;
						state_q <= (s_tuser == ACT_ENCODE) ? ST_SEARCH : ST_DEC;
					end
				end
				ST_SEARCH: begin
					if (sres.fits) begin
						len_q   <= cnt_q;
						cnt_q   <= '0;
						state_q <= ST_EMIT;
					end else if (cnt_q == SEARCH_LAST) begin
						len_q   <= LEN_MAX;
						cnt_q   <= '0;
						state_q <= ST_EMIT;
					end else begin
						cnt_q <= cnt_q + 4'd1;
					end
				end
				ST_EMIT: begin
					if (emit_ld) begin
						if (enc_last) begin
							state_q <= ST_IDLE;
						end else begin
							cnt_q <= cnt_q + 4'd1;
						end
					end
				end
				ST_DEC: begin
					if (!done) begin
						bytes_seen_q <= seen_nxt;
						exp_len_q    <= len_nxt;
						acc_q        <= acc_nxt;
						state_q      <= ST_IDLE;
					end else if (dec_ld) begin
						bytes_seen_q <= '0;
						exp_len_q    <= len_nxt;
						acc_q        <= acc_nxt;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			val_q  <= s_tdata[VAL_W-1:0];
			byte_q <= s_tdata[VAL_W +: BYTE_W];
		end
		if (emit_ld) begin
			m_tdata_q <= {4'b0000, {VAL_W{1'b0}}, len_q, enc_byte};
			m_tuser_q <= KIND_BYTE;
			m_tlast_q <= enc_last;
		end else if (dec_ld) begin
			m_tdata_q <= {4'b0000, sres.ext, len_nxt, {BYTE_W{1'b0}}};
			m_tuser_q <= KIND_VALUE;
			m_tlast_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

endmodule

`default_nettype wire

// ===== hw/rtl/pvc_sva.sv =====
// ----------------------------------------------------------------------------
// Prefix varint codec port checks
// Port-level properties of the codec, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "prefix_varint_codec_macros.svh"

module pvc_sva (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          s_tready,
	input wire logic                          m_tvalid,
	input wire logic                          m_tready,
	input wire logic [pvc_pkg::M_TDATA_W-1:0] m_tdata,
	input wire logic                          m_tuser,
	input wire logic                          m_tlast
);
	import pvc_pkg::*;

	`PVC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output beat changed while stalled")
	`PVC_ASSERT_IMPL(a_value_clean, m_tvalid && (m_tuser == KIND_VALUE), !m_tlast && (m_tdata[7:0] == 8'h00) && (m_tdata[11:8] != 4'd0) && (m_tdata[11:8] <= LEN_MAX), "bad decoded value beat")
	`PVC_ASSERT_IMPL(a_byte_clean, m_tvalid && (m_tuser == KIND_BYTE), (m_tdata[75:12] == 64'd0) && (m_tdata[11:8] != 4'd0) && (m_tdata[11:8] <= LEN_MAX), "bad encoded byte beat")
	`PVC_ASSERT_IMPL(a_run_busy, m_tvalid && (m_tuser == KIND_BYTE) && !m_tlast, !s_tready, "input ready in the middle of an encoded run")

endmodule

bind prefix_varint_codec pvc_sva u_pvc_sva (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

`default_nettype wire

// ===== tb/pvc_codec_checker.sv =====
// ----------------------------------------------------------------------------
// Prefix varint codec checker
// Watches both stream channels of the codec. Every accepted input beat runs
// through a local model of the encoder and the byte-wise decoder, and the
// predicted result beats are queued. Every accepted output beat is compared
// field by field with the oldest queued beat. Hands the failure count and
// the number of outstanding beats to the testbench top.
// ----------------------------------------------------------------------------
module pvc_codec_checker import pvc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic                 s_tuser,
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [M_TDATA_W-1:0] m_tdata,
	input  logic                 m_tuser,
	input  logic                 m_tlast,
	output int                   fail_count,
	output int                   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic              kind;
		logic [BYTE_W-1:0] code_byte;
		logic              last;
		logic [LEN_W-1:0]  len;
		logic [VAL_W-1:0]  value;
	} codec_beat_t;

	codec_beat_t      expected_beats[$];
	logic [LEN_W-1:0] dec_count = '0;
	logic [LEN_W-1:0] dec_len   = '0;
	logic [VAL_W-1:0] dec_acc   = '0;
	int               errs      = 0;

	initial begin
		fail_count = 0;
		pending    = 0;
	end

	function automatic logic [VAL_W-1:0] sign_ext(input logic [VAL_W-1:0] v, input int nbits);
		return $signed(v << (VAL_W - nbits)) >>> (VAL_W - nbits);
	endfunction

	function automatic string fmt_beat(input codec_beat_t r);
		return $sformatf("kind=%0d byte=%02h last=%0d len=%0d value=%016h",
			r.kind, r.code_byte, r.last, r.len, r.value);
	endfunction

	task automatic predict_encode(input logic [VAL_W-1:0] v);
		int                len;
		logic [BYTE_W-1:0] b;
		codec_beat_t       r;
		len = 9;
		// shortest length wins
		for (int k = 8; k >= 1; k--)
			if (sign_ext(v, 7 * k) == v)
				len = k;
		for (int k = 0; k < len; k++) begin
			b = BYTE_W'(v >> (8 * (len - 1 - k)));
			if (k == 0) begin
				if (len <= 7)
					b = (b & (8'hFF >> len)) | (8'hFF << (9 - len));
				else
					b = (len == 8) ? 8'hFE : 8'hFF;
			end
			r.kind      = KIND_BYTE;
			r.code_byte = b;
			r.last      = (k == len - 1);
			r.len       = LEN_W'(len);
			r.value     = '0;
			expected_beats.push_back(r);
		end
	endtask

	task automatic predict_decode(input logic [BYTE_W-1:0] b);
		int          ones;
		codec_beat_t r;
		if (dec_count == 0) begin
			ones = 0;
			while (ones < 8 && b[7 - ones])
				ones++;
			dec_len = (ones == 8) ? LEN_MAX : LEN_W'(ones + 1);
			dec_acc = '0;
			if (dec_len < 8)
				dec_acc[BYTE_W-1:0] = b & (8'hFF >> dec_len);
			dec_count = 4'd1;
		end else begin
			dec_acc   = {dec_acc[VAL_W-BYTE_W-1:0], b};
			dec_count = dec_count + 1'b1;
		end
		if (dec_count >= dec_len) begin
			r.kind      = KIND_VALUE;
			r.code_byte = '0;
			r.last      = 1'b0;
			r.len       = dec_len;
			r.value     = (dec_len <= 8) ? sign_ext(dec_acc, 7 * dec_len) : dec_acc;
			expected_beats.push_back(r);
			dec_count = '0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		codec_beat_t got;
		codec_beat_t want;
		if (!arst_n) begin
			dec_count = '0;
			dec_len   = '0;
			dec_acc   = '0;
			expected_beats.delete();
			pending <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				if (s_tuser == ACT_ENCODE)
					predict_encode(s_tdata[VAL_W-1:0]);
				else
					predict_decode(s_tdata[VAL_W+BYTE_W-1:VAL_W]);
			end
			if (m_tvalid && m_tready) begin
				got.kind      = m_tuser;
				got.code_byte = m_tdata[BYTE_W-1:0];
				got.last      = m_tlast;
				got.len       = m_tdata[BYTE_W+LEN_W-1:BYTE_W];
				got.value     = m_tdata[BYTE_W+LEN_W+VAL_W-1:BYTE_W+LEN_W];
				if (expected_beats.size() == 0) begin
					errs++;
					if (errs <= 10)
						$display("%0t: unexpected result beat: %s", $realtime, fmt_beat(got));
				end else begin
					want = expected_beats.pop_front();
					if (got !== want) begin
						errs++;
						if (errs <= 10)
							$display("%0t: mismatch\n  exp %s\n  got %s", $realtime,
								fmt_beat(want), fmt_beat(got));
					end
				end
			end
			pending    <= expected_beats.size();
			fail_count <= errs;
		end
	end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// Prefix varint codec testbench
// Drives encode and decode beats into the codec: a directed set of range
// boundaries and complete codes, then random values and well-formed codes of
// every length with encodes slipped into partial codes, plus stray bytes.
// Both sides throttle at random in the first two of three phases; the third runs
// unthrottled. The checker predicts and compares the result stream; the verdict
// comes from its failure count.
module tb_top import pvc_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 200_000;
	localparam int RAND_ITEMS  = 108;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;
	logic                 s_tuser  = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 m_tuser;
	logic                 m_tlast;

	int fail_count;
	int pending;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int sent        = 0;
	int cycles      = 0;

	prefix_varint_codec dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	pvc_codec_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic send_beat(input logic act, input logic [VAL_W-1:0] v,
		input logic [BYTE_W-1:0] b);
		int gap;
		gap = 0;
		while (gap < 40 && $urandom_range(99) < tx_idle_pct)
			gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {b, v};
		s_tuser  <= act;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sent++;
	endtask

	task automatic send_encode(input logic [VAL_W-1:0] v);
		send_beat(ACT_ENCODE, v, BYTE_W'($urandom));
	endtask

	task automatic send_decode(input logic [BYTE_W-1:0] b);
		send_beat(ACT_DECODE, {$urandom, $urandom}, b);
	endtask

	// random value for a random code length, often at or just past a range edge
	function automatic logic [VAL_W-1:0] rand_value();
		int               len;
		int               nb;
		logic [VAL_W-1:0] v;
		logic [VAL_W-1:0] lo;
		len = $urandom_range(1, 9);
		nb  = (len == 9) ? VAL_W : 7 * len;
		lo  = {VAL_W{1'b1}} << (nb - 1);
		v   = {$urandom, $urandom};
		if (len < 9)
			v = $signed(v << (VAL_W - nb)) >>> (VAL_W - nb);
		case ($urandom_range(7))
			0: v = lo;
			1: v = ~lo;
			2: v = ~lo + 1'b1;
			3: v = lo - 1'b1;
			default: ;
		endcase
		return v;
	endfunction

	// well-formed code of the given length, random payload, stray encodes
	task automatic send_code(input int len);
		logic [BYTE_W-1:0] b;
		if (len <= 7)
			b = BYTE_W'(($urandom & (8'hFF >> len)) | (8'hFF << (9 - len)));
		else
			b = (len == 8) ? 8'hFE : 8'hFF;
		send_decode(b);
		for (int k = 1; k < len; k++) begin
			if ($urandom_range(7) == 0)
				send_encode(rand_value());
			send_decode(BYTE_W'($urandom));
		end
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	initial begin
		int pick;
		int target;
		tx_idle_pct = 30;
		rx_idle_pct <= 64;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_encode(64'd0);
		send_encode(64'd63);
		send_encode(64'hFFFF_FFFF_FFFF_FFC0);
		send_encode(64'd64);
		send_encode(64'hFFFF_FFFF_FFFF_FFBF);
		send_encode(64'h007F_FFFF_FFFF_FFFF);
		send_encode(64'hFF80_0000_0000_0000);
		send_encode(64'h0080_0000_0000_0000);
		send_encode(64'h7FFF_FFFF_FFFF_FFFF);
		send_encode(64'h8000_0000_0000_0000);
		send_decode(8'h3F);
		send_decode(8'h40);
		// nine-byte code, an encode arrives mid-code
		send_decode(8'hFF);
		send_decode(8'h80);
		send_encode(64'hFFFF_FFFF_FFFF_FFFF);
		repeat (7) send_decode(8'h00);

		for (int ph = 0; ph < 3; ph++) begin
			if (ph > 0) begin
				wait_drained();
				tx_idle_pct = (ph == 1) ? 64 : 0;
				rx_idle_pct <= (ph == 1) ? 30 : 0;
			end
			target = sent + RAND_ITEMS / 3;
			while (sent < target) begin
				pick = $urandom_range(9);
				if (pick < 4)
					send_encode(rand_value());
				else if (pick < 9)
					send_code($urandom_range(1, 9));
				else
					send_decode(BYTE_W'($urandom));
			end
		end

		wait_drained();
		repeat (30) @(posedge clk);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/pvc_pkg.sv
hw/rtl/pvc_sext_unit.sv
hw/rtl/pvc_byte_pick.sv
hw/rtl/prefix_varint_codec.sv
hw/rtl/pvc_sva.sv
tb/pvc_codec_checker.sv
tb/tb_top.sv
